[design/glce_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types of the GIF LZW code encoder.
// Depends on nothing; every other file of the block imports it.
package glce_pkg;

   localparam int DICT_CODES   = 4096;
   localparam int SYMBOL_COUNT = 256;

   localparam int CODE_W     = 12;
   localparam int WIDTH_W    = 4;
   localparam int PIX_W      = 8;
   localparam int DEPTH_W    = 4;
   localparam int SYM_W      = $clog2(SYMBOL_COUNT);
   localparam int DICT_IDX_W = $clog2(DICT_CODES);
   localparam int SLOT_W     = DICT_IDX_W + SYM_W;
   localparam int DICT_ENTRIES = DICT_CODES * SYMBOL_COUNT;

   localparam logic [CODE_W-1:0]  LAST_CODE   = CODE_W'(DICT_CODES - 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd8;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 4'd12;

   // One pixel after classification by the front end.
   typedef struct packed {
      logic [SYM_W-1:0]   sym;
      logic               first;
      logic               last;
      logic [DEPTH_W-1:0] depth;
   } glce_item_type;

   // One output code.
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [WIDTH_W-1:0] code_width;
      logic               run_end;
      logic               image_end;
   } glce_result_type;

   // Access bundle toward the dictionary memories.
   typedef struct packed {
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_slot;
      logic               own_rd_en;
      logic [CODE_W-1:0]  own_rd_code;
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_slot;
      logic [CODE_W-1:0]  wr_code;
   } glce_dict_req_type;

   typedef struct packed {
      logic [CODE_W-1:0] hit_code;
      logic [SLOT_W-1:0] owner_slot;
   } glce_dict_rsp_type;

endpackage

[design/glce_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the GIF LZW code encoder: pixel input, code output
// and configuration write. Depends on glce_pkg.
interface glce_req_if;
   import glce_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_index;
   logic             last_pixel;
   modport source (output valid, pixel_index, last_pixel, input ready);
   modport sink (input valid, pixel_index, last_pixel, output ready);
endinterface

interface glce_rsp_if;
   import glce_pkg::*;
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  code;
   logic [WIDTH_W-1:0] code_width;
   logic               run_end;
   logic               image_end;
   modport source (output valid, code, code_width, run_end, image_end, input ready);
   modport sink (input valid, code, code_width, run_end, image_end, output ready);
endinterface

interface glce_csr_if;
   import glce_pkg::*;
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] lzw_depth;
   modport source (output valid, lzw_depth, input ready);
   modport sink (input valid, lzw_depth, output ready);
endinterface

[design/glce_front.sv]
`timescale 1ns / 1ps
// Front end: configuration register, pixel classification and the two-entry
// queue toward the back end. Depends on glce_pkg and glce_if.
module glce_front (
   input  logic                   clock,
   input  logic                   reset,
   glce_req_if.sink               req_ch,
   glce_csr_if.sink               csr_ch,
   input  logic                   pop,
   output logic                   item_valid,
   output glce_pkg::glce_item_type item
);
   import glce_pkg::*;

   function automatic logic [DEPTH_W-1:0] clamp_depth(logic [DEPTH_W-1:0] m);
      logic [DEPTH_W-1:0] r;
      r = m;
      if (m < DEPTH_MIN) r = DEPTH_MIN;
      if (m > DEPTH_MAX) r = DEPTH_MAX;
      return r;
   endfunction

   logic [DEPTH_W-1:0] csr_ff, csr_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in, depth_now;
   logic               open_ff, open_in;
   glce_item_type      q_ff [2];
   glce_item_type      new_item;
   logic               wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               accept;
   logic               do_pop;
   logic [PIX_W:0]     mask9;
   logic [PIX_W-1:0]   masked;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (cnt_ff != 2'd2);
   assign accept       = req_ch.valid && req_ch.ready;
   assign item_valid   = (cnt_ff != 2'd0);
   assign item         = q_ff[rd_ptr_ff];
   assign do_pop       = pop && item_valid;

   always_comb begin
      csr_in    = csr_ch.valid ? csr_ch.lzw_depth : csr_ff;
      // The depth is latched on the first pixel of each image.
      depth_now = open_ff ? depth_ff : clamp_depth(csr_ff);
      mask9     = (9'(1) << depth_now) - 9'(1);
      masked    = req_ch.pixel_index & mask9[PIX_W-1:0];
      if ({1'b0, masked} >= 9'(SYMBOL_COUNT)) begin
         new_item.sym = SYM_W'(SYMBOL_COUNT - 1);
      end else begin
         new_item.sym = masked[SYM_W-1:0];
      end
      new_item.first = !open_ff;
      new_item.last  = req_ch.last_pixel;
      new_item.depth = depth_now;
      open_in   = accept ? !req_ch.last_pixel : open_ff;
      depth_in  = accept ? depth_now : depth_ff;
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(accept) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff    <= DEPTH_RESET;
         depth_ff  <= DEPTH_RESET;
         open_ff   <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         csr_ff    <= csr_in;
         depth_ff  <= depth_in;
         open_ff   <= open_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[design/glce_dict.sv]
`timescale 1ns / 1ps
// Dictionary memory keyed by prefix and symbol, plus the owner table that maps
// each assigned code back to its slot. Depends on glce_pkg.
module glce_dict (
   input  logic                       clock,
   input  logic                       reset,
   input  glce_pkg::glce_dict_req_type dreq,
   output glce_pkg::glce_dict_rsp_type drsp
);
   import glce_pkg::*;

   logic [CODE_W-1:0] dict_ff  [DICT_ENTRIES];
   logic [SLOT_W-1:0] owner_ff [DICT_CODES];
   logic [CODE_W-1:0] dict_rd_ff;
   logic [CODE_W-1:0] fwd_code_ff;
   logic              fwd_ff;
   logic [SLOT_W-1:0] owner_rd_ff;

   always_ff @(posedge clock) begin
      if (dreq.wr_en) begin
         dict_ff[dreq.wr_slot] <= dreq.wr_code;
      end
      if (dreq.rd_en) begin
         dict_rd_ff  <= dict_ff[dreq.rd_slot];
         fwd_code_ff <= dreq.wr_code;
      end
   end

   always_ff @(posedge clock) begin
      if (dreq.wr_en) begin
         owner_ff[dreq.wr_code[DICT_IDX_W-1:0]] <= dreq.wr_slot;
      end
      if (dreq.own_rd_en) begin
         owner_rd_ff <= owner_ff[dreq.own_rd_code[DICT_IDX_W-1:0]];
      end
   end

   // A read that hits the slot being written in the same cycle returns the
   // new value.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (dreq.rd_en) begin
         fwd_ff <= dreq.wr_en && (dreq.wr_slot == dreq.rd_slot);
      end
   end

   assign drsp.hit_code   = fwd_ff ? fwd_code_ff : dict_rd_ff;
   assign drsp.owner_slot = owner_rd_ff;

endmodule

[design/glce_back.sv]
`timescale 1ns / 1ps
// Back end: LZW run tracking, dictionary lookup and insert, code width and
// clear handling, and sequencing of the output codes. Depends on glce_pkg.
module glce_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  glce_pkg::glce_item_type     item,
   output logic                        pop,
   output glce_pkg::glce_dict_req_type dreq,
   input  glce_pkg::glce_dict_rsp_type drsp,
   output logic                        push_valid,
   output glce_pkg::glce_result_type   push_data,
   input  logic                        push_space
);
   import glce_pkg::*;

   typedef struct packed {
      glce_result_type [4:0] res;
      logic [2:0]            cnt;
   } glce_plan_type;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DICT  = 2'd1;
   localparam logic [1:0] ST_OWNER = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   function automatic glce_plan_type build_plan(
      logic               lead_en,
      logic [CODE_W-1:0]  lead_code,
      logic [WIDTH_W-1:0] lead_width,
      logic               over_en,
      logic [WIDTH_W-1:0] over_width,
      logic               last,
      logic [CODE_W-1:0]  tail_code,
      logic [WIDTH_W-1:0] tail_width,
      logic [CODE_W-1:0]  clr_code,
      logic [WIDTH_W-1:0] base_width
   );
      glce_plan_type p;
      logic [2:0]    n;
      p = '0;
      n = 3'd0;
      if (lead_en) begin
         p.res[n].code       = lead_code;
         p.res[n].code_width = lead_width;
         n = n + 3'd1;
      end
      if (over_en) begin
         p.res[n].code       = clr_code;
         p.res[n].code_width = over_width;
         n = n + 3'd1;
      end
      if (last) begin
         p.res[n].code       = tail_code;
         p.res[n].code_width = tail_width;
         n = n + 3'd1;
         p.res[n].code       = clr_code;
         p.res[n].code_width = tail_width;
         n = n + 3'd1;
         p.res[n].code       = clr_code + CODE_W'(1);
         p.res[n].code_width = base_width;
         p.res[n].image_end  = 1'b1;
         n = n + 3'd1;
      end
      if (n != 3'd0) begin
         p.res[n - 3'd1].run_end = 1'b1;
      end
      p.cnt = n;
      return p;
   endfunction

   logic [1:0]            state_ff, state_in;
   glce_item_type         cur_ff, cur_in;
   logic [CODE_W-1:0]     prefix_ff, prefix_in;
   logic [CODE_W-1:0]     next_ff, next_in;
   logic [WIDTH_W-1:0]    width_ff, width_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   glce_result_type [3:0] plan_ff, plan_in;
   logic [2:0]            plan_cnt_ff, plan_cnt_in;

   logic [CODE_W-1:0]  clr_code, next1, dec_prefix, dec_next;
   logic [WIDTH_W-1:0] width1, dec_width, base_width;
   logic [SLOT_W-1:0]  slot_cur;
   logic               hit_ok, miss, overflow;
   glce_plan_type      dec_plan, first_plan;
   logic [CODE_W-1:0]  f_clear;
   logic [WIDTH_W-1:0] f_width;
   logic [CODE_W-1:0]  base_prefix;
   logic               done;

   // Lookup decision for the item in flight.
   always_comb begin
      clr_code   = CODE_W'(1) << depth_ff;
      base_width = WIDTH_W'(depth_ff) + WIDTH_W'(1);
      slot_cur   = {prefix_ff[DICT_IDX_W-1:0], cur_ff.sym};
      // A stored code counts only if it was assigned in the current
      // dictionary and the owner table points back at this slot.
      hit_ok = (drsp.hit_code >= clr_code + CODE_W'(2)) &&
               (drsp.hit_code <= next_ff) &&
               (drsp.owner_slot == slot_cur);
      // An entry that was never written reads as unknown in simulation and
      // counts as a miss as well.
      miss     = (hit_ok !== 1'b1);
      next1    = next_ff + CODE_W'(1);
      overflow = (next1 >= LAST_CODE);
      if ((width_ff < WIDTH_MAX) && ({1'b0, next1} >= (13'(1) << width_ff))) begin
         width1 = width_ff + WIDTH_W'(1);
      end else begin
         width1 = width_ff;
      end
      if (miss) begin
         dec_prefix = CODE_W'(cur_ff.sym);
         dec_width  = overflow ? base_width : width1;
         dec_next   = overflow ? clr_code + CODE_W'(1) : next1;
      end else begin
         dec_prefix = drsp.hit_code;
         dec_width  = width_ff;
         dec_next   = next_ff;
      end
      dec_plan = build_plan(miss, prefix_ff, width_ff, miss && overflow, width1,
                            cur_ff.last, dec_prefix, dec_width, clr_code, base_width);
   end

   // Codes for the first pixel of an image.
   always_comb begin
      f_clear    = CODE_W'(1) << item.depth;
      f_width    = WIDTH_W'(item.depth) + WIDTH_W'(1);
      first_plan = build_plan(1'b1, f_clear, f_width, 1'b0, f_width, item.last,
                              CODE_W'(item.sym), f_width, f_clear, f_width);
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      prefix_in   = prefix_ff;
      next_in     = next_ff;
      width_in    = width_ff;
      depth_in    = depth_ff;
      plan_in     = plan_ff;
      plan_cnt_in = plan_cnt_ff;
      pop         = 1'b0;
      dreq        = '0;
      push_valid  = 1'b0;
      push_data   = plan_ff[0];
      done        = 1'b0;
      base_prefix = prefix_ff;

      case (state_ff)
         ST_IDLE: begin
            done = 1'b1;
         end
         ST_DICT: begin
            dreq.own_rd_en   = 1'b1;
            dreq.own_rd_code = drsp.hit_code;
            state_in         = ST_OWNER;
         end
         ST_OWNER: begin
            if (push_space) begin
               dreq.wr_en   = miss;
               dreq.wr_slot = slot_cur;
               dreq.wr_code = next1;
               push_valid   = (dec_plan.cnt != 3'd0);
               push_data    = dec_plan.res[0];
               prefix_in    = dec_prefix;
               base_prefix  = dec_prefix;
               width_in     = dec_width;
               next_in      = dec_next;
               for (int i = 0; i < 4; i++) begin
                  plan_in[i] = dec_plan.res[i+1];
               end
               if (dec_plan.cnt > 3'd1) begin
                  plan_cnt_in = dec_plan.cnt - 3'd1;
                  state_in    = ST_EMIT;
               end else begin
                  plan_cnt_in = 3'd0;
                  done        = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (push_space) begin
               push_valid = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  plan_in[i] = plan_ff[i+1];
               end
               plan_in[3]  = '0;
               plan_cnt_in = plan_cnt_ff - 3'd1;
               if (plan_cnt_ff == 3'd1) begin
                  done = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Start the next pixel as soon as the current one is finished.
      if (done) begin
         if (item_valid) begin
            pop = 1'b1;
            if (item.first) begin
               prefix_in = CODE_W'(item.sym);
               next_in   = f_clear + CODE_W'(1);
               width_in  = f_width;
               depth_in  = item.depth;
               for (int i = 0; i < 4; i++) begin
                  plan_in[i] = first_plan.res[i];
               end
               plan_cnt_in = first_plan.cnt;
               state_in    = ST_EMIT;
            end else begin
               dreq.rd_en   = 1'b1;
               dreq.rd_slot = {base_prefix[DICT_IDX_W-1:0], item.sym};
               cur_in       = item;
               state_in     = ST_DICT;
            end
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prefix_ff   <= '0;
         next_ff     <= (CODE_W'(1) << DEPTH_RESET) + CODE_W'(1);
         width_ff    <= WIDTH_W'(DEPTH_RESET) + WIDTH_W'(1);
         depth_ff    <= DEPTH_RESET;
         plan_cnt_ff <= 3'd0;
      end else begin
         state_ff    <= state_in;
         prefix_ff   <= prefix_in;
         next_ff     <= next_in;
         width_ff    <= width_in;
         depth_ff    <= depth_in;
         plan_cnt_ff <= plan_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      plan_ff <= plan_in;
   end

endmodule

[design/glce_rsp_queue.sv]
`timescale 1ns / 1ps
// Two-entry output queue that registers the codes and drives the result
// channel. Depends on glce_pkg and glce_if.
module glce_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  glce_pkg::glce_result_type push_data,
   output logic                      push_space,
   glce_rsp_if.source                rsp_ch
);
   import glce_pkg::*;

   glce_result_type q_ff [2];
   glce_result_type head;
   logic            wr_ptr_ff, rd_ptr_ff;
   logic [1:0]      cnt_ff;
   logic            do_push, do_pop;

   assign push_space = (cnt_ff != 2'd2);
   assign do_push    = push_valid && push_space;
   assign do_pop     = rsp_ch.valid && rsp_ch.ready;
   assign head       = q_ff[rd_ptr_ff];

   assign rsp_ch.valid      = (cnt_ff != 2'd0);
   assign rsp_ch.code       = head.code;
   assign rsp_ch.code_width = head.code_width;
   assign rsp_ch.run_end    = head.run_end;
   assign rsp_ch.image_end  = head.image_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ do_push;
         rd_ptr_ff <= rd_ptr_ff ^ do_pop;
         cnt_ff    <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/gif_lzw_code_encoder_unit.sv]
`timescale 1ns / 1ps
// GIF LZW code encoder, top level. A code for a pixel not first in its image
// leaves after the input queue, dictionary read and owner-table read. The back
// end ends one pixel before it takes the next: dictionary read, owner-table
// read, then an emit step per extra code (clear, footer); a first pixel emits
// one code per cycle while the output queue has room. Synchronous active-high
// reset clears control state only; the dictionary memory is never swept.
module gif_lzw_code_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   glce_req_if.sink   req_ch,
   glce_csr_if.sink   csr_ch,
   glce_rsp_if.source rsp_ch
);
   import glce_pkg::*;

   // The front end takes pixel transactions into a two-entry queue whenever
   // that queue has room, so pixels keep flowing while the back end is busy
   // with a lookup or while codes wait on the result channel. It also holds
   // the code depth register, which is sampled once per image on the
   // first pixel, and reduces each pixel to a symbol.
   logic            item_valid;
   glce_item_type   item;
   logic            pop;

   // The back end works on one pixel at a time: a dictionary read at the
   // prefix and symbol, then an owner-table read at the code found. Stale
   // entries left by an earlier dictionary are rejected because the code is
   // outside the range assigned so far or its owner entry names another slot,
   // which is why no clearing pass is needed after reset or a clear code.
   glce_dict_req_type dreq;
   glce_dict_rsp_type drsp;

   // Codes go through a two-entry output queue, so the back end keeps going
   // while a finished code waits to be taken.
   logic            push_valid;
   glce_result_type push_data;
   logic            push_space;

   glce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   glce_dict u_dict (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   glce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .pop        (pop),
      .dreq       (dreq),
      .drsp       (drsp),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_space (push_space)
   );

   glce_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_space (push_space),
      .rsp_ch     (rsp_ch)
   );

endmodule
